### design/idq_pkg.sv
// Shared types, sizes and helper functions for the indexed double-ended queue.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps
`default_nettype none

package idq_pkg;

   // Queue geometry
   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;

   // Field widths of the request and response transfers
   localparam int OPCODE_W = 3;
   localparam int POS_W    = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   // Command queue between the front and back halves
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4,
      OP_WRITE      = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One classified request, handed from the front to the back
   typedef struct packed {
      logic                   mem_we;
      logic                   mem_re;
      logic [IDX_W-1:0]       addr;
      logic [VALUE_WIDTH-1:0] wdata;
      status_type             status;
      logic [OCC_W-1:0]       occupancy;
   } cmd_type;

   // Sign-extend or truncate a request value into the stored width
   function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [DATA_W-1:0] v);
      logic [63:0] wide;
      wide = 64'($signed(v));
      return wide[VALUE_WIDTH-1:0];
   endfunction

   // Sign-extend a stored value and trim it to the response field
   function automatic logic [DATA_W-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
      logic [63:0] wide;
      wide = 64'($signed(v));
      return wide[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

### design/idq_req_if.sv
// Request channel: valid/ready handshake with opcode, position and value.
// Depends on idq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface idq_req_if import idq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] item_value;

   modport source (output valid, output opcode, output position, output item_value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input item_value,
                   output ready);
endinterface

`default_nettype wire

### design/idq_rsp_if.sv
// Response channel: valid/ready handshake with value, status and occupancy.
// Depends on idq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface idq_rsp_if import idq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [STATUS_W-1:0]      status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output result_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input result_value, input status, input occupancy,
                   output ready);
endinterface

`default_nettype wire

### design/idq_front.sv
// Front half: accepts requests, owns front pointer and count, emits commands.
// Depends on idq_pkg and idq_req_if.
`timescale 1ns / 1ps
`default_nettype none

module idq_front import idq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   idq_req_if.sink req,
   output cmd_type cmd,
   output logic    cmd_valid,
   input  logic    cmd_ready
);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             full;
   logic             empty;
   logic             pos_ok;

   // (base + off) mod DEPTH; both operands stay below DEPTH when used
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
      return sum[IDX_W-1:0];
   endfunction

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;
   assign accept    = req.valid && cmd_ready;

   assign full   = (count_ff >= CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_ok = (CMP_W'(req.position) < CMP_W'(count_ff));

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      cmd.mem_we    = 1'b0;
      cmd.mem_re    = 1'b0;
      cmd.addr      = front_ff;
      cmd.wdata     = to_store(req.item_value);
      cmd.status    = ST_OK;
      case (req.opcode)
         OP_PUSH_FRONT: begin
            if (full) begin
               cmd.status = ST_FULL;
            end else begin
               front_in   = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
               cmd.mem_we = 1'b1;
               cmd.addr   = front_in;
               count_in   = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.addr   = ring_add(front_ff, count_ff);
               count_in   = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.mem_re = 1'b1;
               cmd.addr   = front_ff;
               front_in   = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.mem_re = 1'b1;
               cmd.addr   = ring_add(front_ff, count_ff - 1'b1);
               count_in   = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (!pos_ok) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.mem_re = 1'b1;
               cmd.addr   = ring_add(front_ff, CNT_W'(req.position));
            end
         end
         OP_WRITE: begin
            if (!pos_ok) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.addr   = ring_add(front_ff, CNT_W'(req.position));
            end
         end
         default: begin
            cmd.status = ST_EMPTY;
         end
      endcase
      cmd.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_W'(DEPTH - 1))
      else $error("front pointer outside ring");

   a_full_only_at_depth: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.status == ST_FULL |-> count_ff == CNT_W'(DEPTH))
      else $error("full status with free space");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.mem_we && (req.opcode == OP_PUSH_FRONT || req.opcode == OP_PUSH_BACK)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("successful push did not grow count");

   a_no_read_and_write: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(cmd.mem_we && cmd.mem_re))
      else $error("command both reads and writes");
`endif

endmodule

`default_nettype wire

### design/idq_cmd_fifo.sv
// Two-entry command queue between front and back halves.
// Depends on idq_pkg for cmd_type and queue sizes.
`timescale 1ns / 1ps
`default_nettype none

module idq_cmd_fifo import idq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_cmd,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_cmd,
   output logic    pop_valid,
   input  logic    pop_ready
);

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (fill_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### design/idq_back.sv
// Back half: executes commands against the entry store, holds the response.
// Depends on idq_pkg and idq_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module idq_back import idq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   idq_rsp_if.source    rsp
);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic                   stage_valid_ff;
   logic                   stage_re_ff;
   status_type             stage_status_ff;
   logic [OCC_W-1:0]       stage_occ_ff;
   logic                   take;

   // Response register frees up when empty or when its transfer completes
   assign cmd_ready = !stage_valid_ff || rsp.ready;
   assign take      = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (take && cmd.mem_we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (take && cmd.mem_re) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (cmd_ready) begin
         stage_valid_ff <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_re_ff     <= cmd.mem_re;
         stage_status_ff <= cmd.status;
         stage_occ_ff    <= cmd.occupancy;
      end
   end

   assign rsp.valid        = stage_valid_ff;
   assign rsp.result_value = stage_re_ff ? $signed(to_out(rdata_ff)) : '0;
   assign rsp.status       = stage_status_ff;
   assign rsp.occupancy    = stage_occ_ff;

endmodule

`default_nettype wire

### design/indexed_double_ended_queue.sv
// Top level of the indexed double-ended queue: front, command queue, back.
// Depends on idq_pkg, idq_req_if, idq_rsp_if, idq_front, idq_cmd_fifo, idq_back.
//
//   Channel   Dir  Handshake      Payload
//   req_if    in   valid/ready    opcode[2:0], position[3:0], item_value[31:0]
//   rsp_if    out  valid/ready    result_value[31:0], status[1:0], occupancy[4:0]
//
// One request per cycle while rsp_if.ready stays high; each transfer yields
// exactly one response (command queue stage, then store access into the
// response register). The store has a single port, used once per command.
// Reset is synchronous and clears pointer, count and all valid flags; the
// store is not cleared, since only live entries are ever read.
// A stalled response holds its register; the two-entry command queue then
// fills and req_if.ready drops until the response transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module indexed_double_ended_queue import idq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   idq_req_if.sink   req_if,
   idq_rsp_if.source rsp_if
);

   // Front side of the command queue
   cmd_type front_cmd;
   logic    front_valid;
   logic    front_ready;

   // Back side of the command queue
   cmd_type back_cmd;
   logic    back_valid;
   logic    back_ready;

   // Front: classifies each request against pointer and count, updates them
   // at once so the next request sees the new state
   idq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   // Decouples acceptance from the response stall
   idq_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_cmd    (back_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   // Back: in-order store access, so writes always land before later reads
   idq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for indexed_double_ended_queue: directed table, then random bursts.
// Depends on idq_pkg, idq_req_if, idq_rsp_if and the design top level.
`timescale 1ns / 1ps

module tb;
   import idq_pkg::*;

   // Opcodes the enum leaves out; the block must answer them as no-ops
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int N_RANDOM    = 810;  // random requests after the table
   localparam int IDLE_LIMIT  = 2000; // cycles without any transfer
   localparam int SETTLE      = 20;   // drain time after the last response
   localparam int HOLD_CYCLES = 300;  // one long response stall
   localparam int HOLD_AT     = 300;  // responses seen before that stall

   // One response as the bench expects it
   typedef struct packed {
      logic [DATA_W-1:0] value;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } deque_rsp_type;

   // Directed row: request, repeat count, and an optional typed-in response
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [POS_W-1:0]    position;
      logic [DATA_W-1:0]   value;
      int                  reps;
      bit                  typed;
      logic [DATA_W-1:0]   want_value;
      status_type          want_status;
      logic [OCC_W-1:0]    want_occ;
   } script_row_type;

   localparam int N_ROWS = 23;
   localparam script_row_type SCRIPT [0:N_ROWS-1] = '{
      // empty queue: every access must miss
      '{OP_POP_FRONT,  4'd0,  32'h0000_0000, 1, 1'b1, 32'h0, ST_EMPTY, 5'd0},
      '{OP_POP_BACK,   4'd0,  32'h0000_0000, 1, 1'b1, 32'h0, ST_EMPTY, 5'd0},
      '{OP_READ,       4'd0,  32'h0000_0000, 1, 1'b1, 32'h0, ST_EMPTY, 5'd0},
      '{OP_WRITE,      4'd15, 32'hFFFF_FFFF, 1, 1'b1, 32'h0, ST_EMPTY, 5'd0},
      '{OP_SPARE_LO,   4'd15, 32'hFFFF_FFFF, 1, 1'b1, 32'h0, ST_EMPTY, 5'd0},
      '{OP_SPARE_HI,   4'd0,  32'h0000_0000, 1, 1'b1, 32'h0, ST_EMPTY, 5'd0},
      // two entries, value extremes at both ends
      '{OP_PUSH_BACK,  4'd0,  32'h7FFF_FFFF, 1, 1'b1, 32'h0, ST_OK, 5'd1},
      '{OP_PUSH_FRONT, 4'd0,  32'h8000_0000, 1, 1'b1, 32'h0, ST_OK, 5'd2},
      '{OP_READ,       4'd0,  32'h0000_0000, 1, 1'b1, 32'h8000_0000, ST_OK, 5'd2},
      '{OP_READ,       4'd1,  32'h0000_0000, 1, 1'b0, 32'h0, ST_OK, 5'd0},
      // index equal to count is out of range
      '{OP_READ,       4'd2,  32'h0000_0000, 1, 1'b1, 32'h0, ST_EMPTY, 5'd2},
      '{OP_WRITE,      4'd1,  32'hFFFF_FFFF, 1, 1'b1, 32'h0, ST_OK, 5'd2},
      '{OP_POP_BACK,   4'd0,  32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, ST_OK, 5'd1},
      '{OP_POP_FRONT,  4'd0,  32'h0000_0000, 1, 1'b1, 32'h8000_0000, ST_OK, 5'd0},
      // fill from both ends, wrapping the front pointer
      '{OP_PUSH_BACK,  4'd0,  32'h0000_0000, 8, 1'b0, 32'h0, ST_OK, 5'd0},
      '{OP_PUSH_FRONT, 4'd15, 32'hFFFF_FFFF, 8, 1'b0, 32'h0, ST_OK, 5'd0},
      // full queue: pushes are dropped
      '{OP_PUSH_BACK,  4'd0,  32'h1234_5678, 1, 1'b1, 32'h0, ST_FULL, 5'd16},
      '{OP_PUSH_FRONT, 4'd15, 32'h1234_5678, 1, 1'b1, 32'h0, ST_FULL, 5'd16},
      '{OP_READ,       4'd15, 32'h0000_0000, 1, 1'b0, 32'h0, ST_OK, 5'd0},
      '{OP_WRITE,      4'd15, 32'h5555_5555, 1, 1'b1, 32'h0, ST_OK, 5'd16},
      '{OP_READ,       4'd15, 32'h0000_0000, 1, 1'b1, 32'h5555_5555, ST_OK, 5'd16},
      '{OP_WRITE,      4'd0,  32'hAAAA_AAAA, 1, 1'b0, 32'h0, ST_OK, 5'd0},
      '{OP_SPARE_HI,   4'd15, 32'hFFFF_FFFF, 1, 1'b1, 32'h0, ST_EMPTY, 5'd16}
   };

   logic clock = 1'b0;
   logic reset;

   idq_req_if req_ch ();
   idq_rsp_if rsp_ch ();

   indexed_double_ended_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   // Shadow copy of the deque: ring store, front pointer, live count
   logic [VALUE_WIDTH-1:0] shadow_slots [DEPTH];
   logic [IDX_W-1:0]       shadow_head;
   int                     shadow_fill;

   deque_rsp_type pending_rsp [$];   // responses owed by the block, oldest first

   int  mismatches = 0;
   int  rsp_seen   = 0;
   int  idle_run   = 0;
   int  n_ok       = 0;
   int  n_miss     = 0;
   int  n_full     = 0;
   int  peak_fill  = 0;
   bit  long_hold  = 1'b0;   // receiver is in its long stall

   // Ring slot of the entry 'offset' places behind the front
   function automatic int ring_index(input int offset);
      return (int'(shadow_head) + offset) % DEPTH;
   endfunction

   // Applies one request to the shadow deque and returns its response.
   // Stored and response widths are both 32, so values pass through as is.
   function automatic deque_rsp_type apply_to_shadow(input logic [OPCODE_W-1:0] op,
                                                     input logic [POS_W-1:0]    pos,
                                                     input logic [DATA_W-1:0]   val);
      deque_rsp_type r;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (shadow_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_head = IDX_W'(ring_index(DEPTH - 1));
               shadow_slots[shadow_head] = val;
               shadow_fill++;
            end
         end
         OP_PUSH_BACK: begin
            if (shadow_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_slots[ring_index(shadow_fill)] = val;
               shadow_fill++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = shadow_slots[shadow_head];
               shadow_head = IDX_W'(ring_index(1));
               shadow_fill--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = shadow_slots[ring_index(shadow_fill - 1)];
               shadow_fill--;
            end
         end
         OP_READ: begin
            if (int'(pos) >= shadow_fill) r.status = ST_EMPTY;
            else r.value = shadow_slots[ring_index(int'(pos))];
         end
         OP_WRITE: begin
            if (int'(pos) >= shadow_fill) r.status = ST_EMPTY;
            else shadow_slots[ring_index(int'(pos))] = val;
         end
         default: r.status = ST_EMPTY;
      endcase
      r.occupancy = OCC_W'(shadow_fill);
      return r;
   endfunction

   // Idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // Value mix: the four extremes often, otherwise anything
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Index mostly inside the live range, sometimes anywhere (incl. == count)
   function automatic logic [POS_W-1:0] pick_position();
      if (shadow_fill > 0 && $urandom_range(0, 99) < 85)
         return POS_W'($urandom_range(0, shadow_fill - 1));
      return POS_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // Offers one request, waits for its transfer, then books the response
   // it owes: the typed-in one where given, else the shadow's answer.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [POS_W-1:0]    pos,
                               input logic [DATA_W-1:0]   val,
                               input bit                  typed,
                               input deque_rsp_type       want);
      int            gap;
      deque_rsp_type shadow_rsp;
      gap = long_hold ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.position   <= pos;
      req_ch.item_value <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      shadow_rsp = apply_to_shadow(op, pos, val);
      if (typed) shadow_rsp = want;
      pending_rsp.push_back(shadow_rsp);
      case (shadow_rsp.status)
         ST_OK:    n_ok++;
         ST_FULL:  n_full++;
         default:  n_miss++;
      endcase
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
   endtask

   // Random request shaped by the burst kind:
   // 0 fill, 1 drain, 2 indexed access, 3 noise
   task automatic random_request(input int kind);
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      bit                  biased;
      biased = ($urandom_range(0, 99) < 75);
      case (kind)
         0:       op = biased ? ($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT)
                              : OPCODE_W'($urandom_range(0, 7));
         1:       op = biased ? ($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT)
                              : OPCODE_W'($urandom_range(0, 7));
         2:       op = biased ? ($urandom_range(0, 1) ? OP_WRITE : OP_READ)
                              : OPCODE_W'($urandom_range(0, 7));
         default: op = OPCODE_W'($urandom_range(0, 7));
      endcase
      pos = (kind == 3) ? POS_W'($urandom_range(0, DEPTH - 1)) : pick_position();
      send_request(op, pos, pick_value(), 1'b0, '0);
   endtask

   // Inputs known from time zero; reset held until the main sequence releases it
   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= '0;
      req_ch.position   <= '0;
      req_ch.item_value <= '0;
      rsp_ch.ready      <= 1'b0;
   end

   // Receiver: random stalls, long ready stretches, and one long hold-off
   // that backs the block up until it drops req ready.
   initial begin
      int  stall;
      bit  hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            long_hold = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 99) < 80) repeat ($urandom_range(1, 8)) @(posedge clock);
         else repeat ($urandom_range(20, 120)) @(posedge clock);
      end
   end

   // Response checker: each transfer against the oldest booked response
   always @(posedge clock) begin
      deque_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: value %h status %0d occupancy %0d",
                   rsp_ch.result_value, rsp_ch.status, rsp_ch.occupancy);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.result_value !== want.value) begin
               $error("result_value: expected %h, got %h", want.value, rsp_ch.result_value);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: cycles in a row with no transfer on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_run <= 0;
      else idle_run <= idle_run + 1;
   end

   initial begin
      while (idle_run < IDLE_LIMIT) @(posedge clock);
      $display("timeout: %0d cycles without a transfer, %0d responses outstanding",
               idle_run, pending_rsp.size());
      $display("indexed_double_ended_queue: mismatch");
      $finish;
   end

   // Main sequence
   initial begin
      deque_rsp_type want;
      int            sent;
      int            burst_len;
      int            kind;
      shadow_head = '0;
      shadow_fill = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table; the final rows leave the queue full
      for (int i = 0; i < N_ROWS; i++) begin
         want.value     = SCRIPT[i].want_value;
         want.status    = SCRIPT[i].want_status;
         want.occupancy = SCRIPT[i].want_occ;
         repeat (SCRIPT[i].reps)
            send_request(SCRIPT[i].opcode, SCRIPT[i].position, SCRIPT[i].value,
                         SCRIPT[i].typed, want);
      end

      // Random bursts; halfway the sender stops until all responses are in
      sent = 0;
      while (sent < N_RANDOM) begin
         kind      = $urandom_range(0, 3);
         burst_len = $urandom_range(4, 30);
         for (int k = 0; k < burst_len && sent < N_RANDOM; k++) begin
            random_request(kind);
            sent++;
            if (sent == N_RANDOM / 2) begin
               req_ch.valid <= 1'b0;
               do @(posedge clock); while (pending_rsp.size() != 0);
            end
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d requests: %0d ok, %0d empty or out of range, %0d full",
               n_ok + n_miss + n_full, n_ok, n_miss, n_full);
      $display("%0d responses checked, peak occupancy %0d, %0d field mismatches",
               rsp_seen, peak_fill, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("indexed_double_ended_queue: match");
      end else begin
         $display("indexed_double_ended_queue: mismatch");
      end
      $finish;
   end

endmodule
